FILE: src/tvt_pkg.sv
`timescale 1ns / 1ps

package tvt_pkg;

  // Field widths
  localparam int unsigned ActW    = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TagW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned CapW    = 5;

  // Defaults
  localparam int unsigned   MaxSlotsDefault = 16;
  localparam logic [CapW-1:0] CapReset      = 5'd16;

  typedef enum logic [ActW-1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_REMOVE = 2'd2
  } action_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_EXISTS   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_CMP,
    S_MISS,
    S_APPEND,
    S_SHIFT,
    S_MOVE,
    S_RESULT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic    req_load;
    logic    idx_clear;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_use_value;
    logic    res_use_cap;
    logic    out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    action_e action;
    logic    act_valid;
    logic    tag_zero;
    logic    hit;
    logic    last;
    logic    empty;
    logic    has_room;
    logic    out_busy;
  } sts_t;

endpackage

FILE: src/tvt_datapath.sv
`timescale 1ns / 1ps

module tvt_datapath #(
  parameter int unsigned MAX_SLOTS = tvt_pkg::MaxSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tvt_pkg::cmd_t                cmd_i,
  output tvt_pkg::sts_t                sts_o,
  input  logic [tvt_pkg::ActW-1:0]     action_i,
  input  logic [tvt_pkg::TagW-1:0]     tag_i,
  input  logic [tvt_pkg::ValW-1:0]     new_value_i,
  input  logic                         cfg_we_i,
  input  logic [tvt_pkg::CapW-1:0]     cfg_wdata_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [tvt_pkg::StatusW-1:0]  status_o,
  output logic [tvt_pkg::ValW-1:0]     found_value_o
);
  import tvt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_SLOTS);
  localparam int unsigned CntW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned CmpW = ((CntW > CapW) ? CntW : CapW) + 2;

  // Pair store: tag in the upper half, value in the lower
  logic [TagW+ValW-1:0] mem_q [MAX_SLOTS];
  logic [TagW+ValW-1:0] rd_data_q;

  logic [ActW-1:0]    req_action_q;
  logic [TagW-1:0]    req_tag_q;
  logic [ValW-1:0]    req_value_q;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CapW-1:0]    cap_q;
  logic [StatusW-1:0] res_status_q;
  logic [ValW-1:0]    res_value_q, res_value_d;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q;
  logic [ValW-1:0]    out_value_q;

  logic [CntW-1:0]    idx_plus;
  logic [IdxW-1:0]    rd_addr;
  logic [IdxW-1:0]    wr_addr;
  logic [TagW+ValW-1:0] wr_data;
  logic [CmpW-1:0]    cap_ext, max_ext, eff_cap;

  // Effective capacity and address selection
  always_comb begin
    cap_ext  = CmpW'(cap_q);
    max_ext  = CmpW'(MAX_SLOTS);
    eff_cap  = (cap_ext > max_ext) ? max_ext : cap_ext;
    idx_plus = CntW'(idx_q) + CntW'(1);
    rd_addr  = cmd_i.rd_next ? idx_plus[IdxW-1:0] : idx_q;
    wr_addr  = cmd_i.wr_shift ? idx_q : count_q[IdxW-1:0];
    wr_data  = cmd_i.wr_shift ? rd_data_q : {req_tag_q, req_value_q};
  end

  // Status towards the controller
  always_comb begin
    sts_o.action    = action_e'(req_action_q);
    sts_o.act_valid = (req_action_q != 2'd3);
    sts_o.tag_zero  = (req_tag_q == '0);
    sts_o.hit       = (rd_data_q[TagW+ValW-1:ValW] == req_tag_q);
    sts_o.last      = (idx_plus == count_q);
    sts_o.empty     = (count_q == '0);
    sts_o.has_room  = ((CmpW'(count_q) + CmpW'(2)) <= eff_cap);
    sts_o.out_busy  = out_valid_q && out_stall_i;
  end

  // Store access, read data registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_action_q <= action_i;
      req_tag_q    <= tag_i;
      req_value_q  <= new_value_i;
    end
  end

  // Index and fill count
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_plus[IdxW-1:0];
    end
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
      cap_q   <= CapReset;
    end else begin
      idx_q   <= idx_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Result staging
  always_comb begin
    res_value_d = '0;
    if (cmd_i.res_use_value) begin
      res_value_d = rd_data_q[ValW-1:0];
    end else if (cmd_i.res_use_cap) begin
      res_value_d = ValW'(eff_cap);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_value_q  <= res_value_d;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign found_value_o = out_value_q;

endmodule

FILE: src/tvt_ctrl.sv
`timescale 1ns / 1ps

module tvt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tvt_pkg::sts_t sts_i,
  output tvt_pkg::cmd_t cmd_o
);
  import tvt_pkg::*;

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.act_valid || sts_i.tag_zero) begin
          state_d = S_RESULT;
        end else if (sts_i.empty) begin
          state_d = S_MISS;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (sts_i.hit) begin
          state_d = (sts_i.action == ACT_REMOVE) ? S_SHIFT : S_RESULT;
        end else if (sts_i.last) begin
          state_d = S_MISS;
        end else begin
          state_d = S_READ;
        end
      end
      S_MISS: begin
        if (sts_i.action == ACT_SET && sts_i.has_room) begin
          state_d = S_APPEND;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_APPEND: state_d = S_RESULT;
      S_SHIFT:  state_d = sts_i.last ? S_RESULT : S_MOVE;
      S_MOVE:   state_d = S_SHIFT;
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = ST_NOTFOUND;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.req_load  = in_valid_i;
        cmd_o.idx_clear = in_valid_i;
      end
      S_DECODE: begin
        if (!sts_i.act_valid || sts_i.tag_zero) begin
          cmd_o.res_load = 1'b1;
          case (sts_i.action)
            ACT_GET: begin
              cmd_o.res_status  = ST_OK;
              cmd_o.res_use_cap = 1'b1;
            end
            ACT_SET: cmd_o.res_status = ST_EXISTS;
            default: cmd_o.res_status = ST_NOTFOUND;
          endcase
        end
      end
      S_READ: cmd_o.rd_en = 1'b1;
      S_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res_load = (sts_i.action != ACT_REMOVE);
          case (sts_i.action)
            ACT_GET: begin
              cmd_o.res_status    = ST_OK;
              cmd_o.res_use_value = 1'b1;
            end
            ACT_SET: cmd_o.res_status = ST_EXISTS;
            default: cmd_o.res_status = ST_NOTFOUND;
          endcase
        end else if (!sts_i.last) begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_MISS: begin
        if (sts_i.action == ACT_SET) begin
          cmd_o.res_load   = !sts_i.has_room;
          cmd_o.res_status = ST_FULL;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOTFOUND;
        end
      end
      S_APPEND: begin
        cmd_o.wr_en      = 1'b1;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.res_load   = 1'b1;
        cmd_o.res_status = ST_OK;
      end
      S_SHIFT: begin
        if (sts_i.last) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
        end
      end
      S_MOVE: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
      end
      S_RESULT: cmd_o.out_load = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/tagged_value_table.sv
`timescale 1ns / 1ps
// Tagged value table: up to MAX_SLOTS-1 tag/value pairs kept packed at the
// front of a store, tag zero acting as terminator. One request per transaction
// on the input channel (get, set or remove); exactly one result transaction
// (status, found value) on the output channel for each request.
// Both channels use valid/stall: a transaction moves on a rising edge with
// valid high and stall low.
// Sequence: one request at a time. After the accepting edge the block
// decodes the request, then scans pairs through the store, reading and
// comparing each in turn; on a miss it checks, for a set, for room and then
// appends; on a remove hit it shifts each later pair down one slot (read,
// move) and then updates the count; last it loads the output register. A
// tag-zero or unused action goes from decode straight to the result. A new
// request can be accepted from the cycle after the result is loaded.
// If the receiver stalls while the output register still holds a result, the
// block keeps the new result staged and stalls its input until the output
// register frees. Reset clears the pair count and sets slot_capacity to 16;
// store contents are not cleared. The user must write slot_capacity through
// cfg_we_i only while idle; the block itself does not enforce this.
module tagged_value_table #(
  parameter int unsigned MAX_SLOTS = tvt_pkg::MaxSlotsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [tvt_pkg::ActW-1:0]     action_i,
  input  logic [tvt_pkg::TagW-1:0]     tag_i,
  input  logic [tvt_pkg::ValW-1:0]     new_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [tvt_pkg::StatusW-1:0]  status_o,
  output logic [tvt_pkg::ValW-1:0]     found_value_o,
  input  logic                         cfg_we_i,
  input  logic [tvt_pkg::CapW-1:0]     cfg_wdata_i
);
  import tvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  tvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store, counters and result registers
  tvt_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .action_i      (action_i),
    .tag_i         (tag_i),
    .new_value_i   (new_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .found_value_o (found_value_o)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import tvt_pkg::*;

  localparam int unsigned MaxSlots      = MaxSlotsDefault;
  localparam logic [ActW-1:0] ActUnused = 2'd3;
  localparam int unsigned PoolSize      = 20;
  localparam int unsigned PhaseCount    = 12;
  localparam int unsigned PhaseItems    = 152;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 80;
  localparam int unsigned CycleLimit    = 1000000;

  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] value;
  } table_result_t;

  // Scoreboard: mirrors the table contents and queues the expected results
  class table_scoreboard;
    logic [TagW-1:0] tag_mem [MaxSlots];
    logic [ValW-1:0] val_mem [MaxSlots];
    int unsigned     pairs;
    logic [CapW-1:0] capacity;
    table_result_t   expected_q [$];
    int unsigned     mismatches;
    int unsigned     checked;

    function void clear();
      pairs = 0;
      capacity = CapReset;
      expected_q.delete();
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] slots);
      capacity = slots;
    endfunction

    // capacity saturates at the store depth
    function int unsigned usable_slots();
      return (capacity > MaxSlots) ? MaxSlots : int'(capacity);
    endfunction

    // index of the pair holding tag, or the pair count when absent
    function int unsigned locate(logic [TagW-1:0] tag);
      int unsigned i;
      for (i = 0; i < pairs; i++) begin
        if (tag_mem[i] == tag) return i;
      end
      return pairs;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // predict the result of an accepted request and update the mirror
    function void note_request(logic [ActW-1:0] act, logic [TagW-1:0] tag,
                               logic [ValW-1:0] nval);
      table_result_t res;
      int unsigned   pos;
      int unsigned   i;
      res.status = ST_NOTFOUND;
      res.value  = '0;
      case (act)
        ACT_GET: begin
          // the terminator always matches and reports the capacity
          if (tag == '0) begin
            res.status = ST_OK;
            res.value  = usable_slots();
          end else begin
            pos = locate(tag);
            if (pos < pairs) begin
              res.status = ST_OK;
              res.value  = val_mem[pos];
            end
          end
        end
        ACT_SET: begin
          if (tag == '0 || locate(tag) < pairs) begin
            res.status = ST_EXISTS;
          end else if (pairs + 2 <= usable_slots() && pairs < MaxSlots) begin
            // new pair plus the terminator slot must both fit
            tag_mem[pairs] = tag;
            val_mem[pairs] = nval;
            pairs++;
            res.status = ST_OK;
          end else begin
            res.status = ST_FULL;
          end
        end
        ACT_REMOVE: begin
          if (tag != '0) begin
            pos = locate(tag);
            if (pos < pairs) begin
              for (i = pos; i + 1 < pairs; i++) begin
                tag_mem[i] = tag_mem[i+1];
                val_mem[i] = val_mem[i+1];
              end
              pairs--;
              res.status = ST_OK;
            end
          end
        end
        default: ;
      endcase
      expected_q.push_back(res);
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic [StatusW-1:0] st, logic [ValW-1:0] val);
      table_result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: status %0d, found_value 0x%08h",
               st, val);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        mismatches++;
      end
      if (val !== want.value) begin
        $error("found_value: expected 0x%08h, actual 0x%08h", want.value, val);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ActW-1:0]     action_i;
  logic [TagW-1:0]     tag_i;
  logic [ValW-1:0]     new_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [StatusW-1:0]  status_o;
  logic [ValW-1:0]     found_value_o;
  logic                cfg_we_i;
  logic [CapW-1:0]     cfg_wdata_i;

  table_scoreboard sb;
  logic [TagW-1:0] tag_pool [PoolSize];
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  int unsigned     sent;
  int unsigned     cfg_writes;
  int unsigned     cycle_count = 0;

  tagged_value_table #(
    .MAX_SLOTS(MaxSlots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .tag_i        (tag_i),
    .new_value_i  (new_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .found_value_o(found_value_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure, changed on the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: both channels sampled on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(status_o, found_value_o);
      if (in_valid_i && !in_stall_o) sb.note_request(action_i, tag_i, new_value_i);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending());
      $display("tb: errors");
      $finish;
    end
  end

  // One request transaction; valid stays high afterwards until the next call
  // or a release
  task automatic send_request(logic [ActW-1:0] act, logic [TagW-1:0] tag,
                              logic [ValW-1:0] nval);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    action_i    <= act;
    tag_i       <= tag;
    new_value_i <= nval;
    do @(posedge clk_i); while (in_stall_o);
    sent++;
  endtask

  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold off until every expected result has been returned
  task automatic wait_drained();
    release_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Capacity write, only with the block idle
  task automatic write_capacity(logic [CapW-1:0] slots);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= slots;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_capacity(slots);
    cfg_writes++;
  endtask

  // Corner cases: terminator handling, extremes, full table, shrinking and
  // oversized capacity
  task automatic directed_requests();
    send_request(ACT_GET, 32'h0, 32'h0);
    send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_SET, 32'h0, 32'hFFFF_FFFF);
    send_request(ACT_REMOVE, 32'h0, 32'h0);
    send_request(ACT_REMOVE, 32'h1234_5678, 32'h0);
    send_request(ActUnused, 32'h5, 32'hFFFF_FFFF);
    send_request(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(ACT_SET, 32'h1, 32'h0);
    send_request(ACT_SET, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_GET, 32'h1, 32'h0);
    send_request(ACT_SET, 32'h8000_0000, 32'hA5A5_A5A5);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_request(ACT_GET, 32'h8000_0000, 32'h0);
    send_request(ACT_GET, 32'h1, 32'h0);
    write_capacity(5'd4);
    send_request(ACT_SET, 32'h7, 32'h5A5A_5A5A);
    send_request(ACT_SET, 32'h9, 32'h1);
    send_request(ACT_GET, 32'h0, 32'h0);
    // capacity now below the number of stored pairs
    write_capacity(5'd2);
    send_request(ACT_GET, 32'h7, 32'h0);
    send_request(ACT_SET, 32'hA, 32'h2);
    send_request(ACT_REMOVE, 32'h1, 32'h0);
    send_request(ACT_GET, 32'h0, 32'h0);
    write_capacity(5'd31);
    send_request(ACT_GET, 32'h0, 32'h0);
    write_capacity(5'd1);
    send_request(ACT_GET, 32'h0, 32'h0);
    send_request(ACT_SET, 32'h3, 32'h3);
  endtask

  // Random request: tags mostly from a small pool so that hits are common
  task automatic random_request();
    logic [ActW-1:0] act;
    logic [TagW-1:0] tag;
    int unsigned     pick;
    pick = $urandom_range(99);
    if (pick < 40) act = ACT_GET;
    else if (pick < 75) act = ACT_SET;
    else if (pick < 97) act = ACT_REMOVE;
    else act = ActUnused;
    pick = $urandom_range(99);
    if (pick < 4) tag = '0;
    else if (pick < 14) tag = $urandom();
    else tag = tag_pool[$urandom_range(PoolSize-1)];
    send_request(act, tag, $urandom());
  endtask

  // Stimulus
  initial begin
    logic [CapW-1:0] phase_cap [PhaseCount];
    int unsigned     ph;
    int unsigned     n;
    int unsigned     pause_at;

    phase_cap = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd8, 5'd31,
                  5'd16, 5'd5, 5'd20, 5'd15, 5'd4, 5'd16};
    sb = new();
    sb.clear();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = '0;
    tag_i       = '0;
    new_value_i = '0;
    out_stall_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    sent        = 0;
    cfg_writes  = 0;

    tag_pool[0] = 32'hFFFF_FFFF;
    tag_pool[1] = 32'h1;
    for (n = 2; n < PoolSize; n++) begin
      tag_pool[n] = $urandom();
      if (tag_pool[n] == '0) tag_pool[n] = 32'h2;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    directed_requests();

    // Random phases, each with its own capacity and idling pattern
    for (ph = 0; ph < PhaseCount; ph++) begin
      write_capacity(phase_cap[ph]);
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 15; stall_pct = 15; end
      endcase
      pause_at = $urandom_range(20, PhaseItems - 20);
      for (n = 0; n < PhaseItems; n++) begin
        if (n == pause_at) wait_drained();
        random_request();
      end
    end

    // Drain and let any stray transaction show up
    release_input();
    idle_pct = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    stall_pct = 0;
    repeat (TailCycles) @(posedge clk_i);

    $display("summary: %0d requests sent, %0d results checked, %0d capacity writes",
             sent, sb.checked, cfg_writes);
    $display("summary: corner cases first, then random get/set/remove phases with idling");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
